### rtl/core/g2l_pkg.sv
// ----------------------------------------------------------------------------
// g2l_pkg
// shared types, constants and the per-year lunar rom for the date converter
// ----------------------------------------------------------------------------
package g2l_pkg;

  localparam int unsigned TableYears = 202;
  localparam int unsigned IdxW = 8;
  localparam logic [11:0] BaseYear = 12'd1899;
  localparam logic [11:0] LastYear = 12'd2100;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
  } g2l_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } g2l_sts_t;

  function automatic logic [27:0] rom_word(input logic [IdxW-1:0] i);
    logic [27:0] w;
    unique case (i)
      8'd0: w = 28'hAB500D2; 8'd1: w = 28'h4BD0883; 8'd2: w = 28'h4AE00DB;
      8'd3: w = 28'hA5700D0; 8'd4: w = 28'h54D0581; 8'd5: w = 28'hD2600D8;
      8'd6: w = 28'hD9500CC; 8'd7: w = 28'h655147D; 8'd8: w = 28'h56A00D5;
      8'd9: w = 28'h9AD00CA; 8'd10: w = 28'h55D027A; 8'd11: w = 28'h4AE00D2;
      8'd12: w = 28'hA5B0682; 8'd13: w = 28'hA4D00DA; 8'd14: w = 28'hD2500CE;
      8'd15: w = 28'hD25157E; 8'd16: w = 28'hB5500D6; 8'd17: w = 28'h56A00CC;
      8'd18: w = 28'hADA027B; 8'd19: w = 28'h95B00D3; 8'd20: w = 28'h49717C9;
      8'd21: w = 28'h49B00DC; 8'd22: w = 28'hA4B00D0; 8'd23: w = 28'hB4B0580;
      8'd24: w = 28'h6A500D8; 8'd25: w = 28'h6D400CD; 8'd26: w = 28'hAB5147C;
      8'd27: w = 28'h2B600D5; 8'd28: w = 28'h95700CA; 8'd29: w = 28'h52F027B;
      8'd30: w = 28'h49700D2; 8'd31: w = 28'h6560682; 8'd32: w = 28'hD4A00D9;
      8'd33: w = 28'hEA500CE; 8'd34: w = 28'h6A9157E; 8'd35: w = 28'h5AD00D6;
      8'd36: w = 28'h2B600CC; 8'd37: w = 28'h86E137C; 8'd38: w = 28'h92E00D3;
      8'd39: w = 28'hC8D1783; 8'd40: w = 28'hC9500DB; 8'd41: w = 28'hD4A00D0;
      8'd42: w = 28'hD8A167F; 8'd43: w = 28'hB5500D7; 8'd44: w = 28'h56A00CD;
      8'd45: w = 28'hA5B147D; 8'd46: w = 28'h25D00D5; 8'd47: w = 28'h92D00CA;
      8'd48: w = 28'hD2B027A; 8'd49: w = 28'hA9500D2; 8'd50: w = 28'hB550781;
      8'd51: w = 28'h6CA00D9; 8'd52: w = 28'hB5500CE; 8'd53: w = 28'h535157F;
      8'd54: w = 28'h4DA00D6; 8'd55: w = 28'hA5B00CB; 8'd56: w = 28'h457037C;
      8'd57: w = 28'h52B00D4; 8'd58: w = 28'hA9A0883; 8'd59: w = 28'hE9500DA;
      8'd60: w = 28'h6AA00D0; 8'd61: w = 28'hAEA0680; 8'd62: w = 28'hAB500D7;
      8'd63: w = 28'h4B600CD; 8'd64: w = 28'hAAE047D; 8'd65: w = 28'hA5700D5;
      8'd66: w = 28'h52600CA; 8'd67: w = 28'hF260379; 8'd68: w = 28'hD9500D1;
      8'd69: w = 28'h5B50782; 8'd70: w = 28'h56A00D9; 8'd71: w = 28'h96D00CE;
      8'd72: w = 28'h4DD057F; 8'd73: w = 28'h4AD00D7; 8'd74: w = 28'hA4D00CB;
      8'd75: w = 28'hD4D047B; 8'd76: w = 28'hD2500D3; 8'd77: w = 28'hD550883;
      8'd78: w = 28'hB5400DA; 8'd79: w = 28'hB6A00CF; 8'd80: w = 28'h95A1680;
      8'd81: w = 28'h95B00D8; 8'd82: w = 28'h49B00CD; 8'd83: w = 28'hA97047D;
      8'd84: w = 28'hA4B00D5; 8'd85: w = 28'hB270ACA; 8'd86: w = 28'h6A500DC;
      8'd87: w = 28'h6D400D1; 8'd88: w = 28'hAF40681; 8'd89: w = 28'hAB600D9;
      8'd90: w = 28'h93700CE; 8'd91: w = 28'h4AF057F; 8'd92: w = 28'h49700D7;
      8'd93: w = 28'h64B00CC; 8'd94: w = 28'h74A037B; 8'd95: w = 28'hEA500D2;
      8'd96: w = 28'h6B50883; 8'd97: w = 28'h5AC00DB; 8'd98: w = 28'hAB600CF;
      8'd99: w = 28'h96D0580; 8'd100: w = 28'h92E00D8; 8'd101: w = 28'hC9600CD;
      8'd102: w = 28'hD95047C; 8'd103: w = 28'hD4A00D4; 8'd104: w = 28'hDA500C9;
      8'd105: w = 28'h755027A; 8'd106: w = 28'h56A00D1; 8'd107: w = 28'hABB0781;
      8'd108: w = 28'h25D00DA; 8'd109: w = 28'h92D00CF; 8'd110: w = 28'hCAB057E;
      8'd111: w = 28'hA9500D6; 8'd112: w = 28'hB4A00CB; 8'd113: w = 28'hBAA047B;
      8'd114: w = 28'hAD500D2; 8'd115: w = 28'h55D0983; 8'd116: w = 28'h4BA00DB;
      8'd117: w = 28'hA5B00D0; 8'd118: w = 28'h5171680; 8'd119: w = 28'h52B00D8;
      8'd120: w = 28'hA9300CD; 8'd121: w = 28'h795047D; 8'd122: w = 28'h6AA00D4;
      8'd123: w = 28'hAD500C9; 8'd124: w = 28'h5B5027A; 8'd125: w = 28'h4B600D2;
      8'd126: w = 28'h96E0681; 8'd127: w = 28'hA4E00D9; 8'd128: w = 28'hD2600CE;
      8'd129: w = 28'hEA6057E; 8'd130: w = 28'hD5300D5; 8'd131: w = 28'h5AA00CB;
      8'd132: w = 28'h76A037B; 8'd133: w = 28'h96D00D3; 8'd134: w = 28'h4AB0B83;
      8'd135: w = 28'h4AD00DB; 8'd136: w = 28'hA4D00D0; 8'd137: w = 28'hD0B1680;
      8'd138: w = 28'hD2500D7; 8'd139: w = 28'hD5200CC; 8'd140: w = 28'hDD4057C;
      8'd141: w = 28'hB5A00D4; 8'd142: w = 28'h56D00C9; 8'd143: w = 28'h55B027A;
      8'd144: w = 28'h49B00D2; 8'd145: w = 28'hA570782; 8'd146: w = 28'hA4B00D9;
      8'd147: w = 28'hAA500CE; 8'd148: w = 28'hB25157E; 8'd149: w = 28'h6D200D6;
      8'd150: w = 28'hADA00CA; 8'd151: w = 28'h4B6137B; 8'd152: w = 28'h93700D3;
      8'd153: w = 28'h49F08C9; 8'd154: w = 28'h49700DB; 8'd155: w = 28'h64B00D0;
      8'd156: w = 28'h68A1680; 8'd157: w = 28'hEA500D7; 8'd158: w = 28'h6AA00CC;
      8'd159: w = 28'hA6C147C; 8'd160: w = 28'hAAE00D4; 8'd161: w = 28'h92E00CA;
      8'd162: w = 28'hD2E0379; 8'd163: w = 28'hC9600D1; 8'd164: w = 28'hD550781;
      8'd165: w = 28'hD4A00D9; 8'd166: w = 28'hDA400CD; 8'd167: w = 28'h5D5057E;
      8'd168: w = 28'h56A00D6; 8'd169: w = 28'hA6C00CB; 8'd170: w = 28'h55D047B;
      8'd171: w = 28'h52D00D3; 8'd172: w = 28'hA9B0883; 8'd173: w = 28'hA9500DB;
      8'd174: w = 28'hB4A00CF; 8'd175: w = 28'hB6A067F; 8'd176: w = 28'hAD500D7;
      8'd177: w = 28'h55A00CD; 8'd178: w = 28'hABA047C; 8'd179: w = 28'hA5A00D4;
      8'd180: w = 28'h52B00CA; 8'd181: w = 28'hB27037A; 8'd182: w = 28'h69300D1;
      8'd183: w = 28'h7330781; 8'd184: w = 28'h6AA00D9; 8'd185: w = 28'hAD500CE;
      8'd186: w = 28'h4B5157E; 8'd187: w = 28'h4B600D6; 8'd188: w = 28'hA5700CB;
      8'd189: w = 28'h54E047C; 8'd190: w = 28'hD1600D2; 8'd191: w = 28'hE960882;
      8'd192: w = 28'hD5200DA; 8'd193: w = 28'hDAA00CF; 8'd194: w = 28'h6AA167F;
      8'd195: w = 28'h56D00D7; 8'd196: w = 28'h4AE00CD; 8'd197: w = 28'hA9D047D;
      8'd198: w = 28'hA2D00D4; 8'd199: w = 28'hD1500C9; 8'd200: w = 28'hF250279;
      8'd201: w = 28'hD5200D1;
      default: w = '0;
    endcase
    return w;
  endfunction

  // days before the first of month m (1..12), leap february added by caller
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1: r = 9'd0;    4'd2: r = 9'd31;   4'd3: r = 9'd59;   4'd4: r = 9'd90;
      4'd5: r = 9'd120;  4'd6: r = 9'd151;  4'd7: r = 9'd181;  4'd8: r = 9'd212;
      4'd9: r = 9'd243;  4'd10: r = 9'd273; 4'd11: r = 9'd304; 4'd12: r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_leap(input logic [11:0] y);
    logic c;
    c = (y == 12'd1900) || (y == 12'd2100);
    return (y[1:0] == 2'b00) && !c;
  endfunction

endpackage

### rtl/core/gregorian_to_chinese_lunar_date_top.sv
// one conversion at a time: a new start is taken only while the controller is idle
// the month walk in the datapath takes one step per month, up to 13 months
// reset: synchronous active-low rst_n returns the controller to idle
// results are shown for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
// gregorian_to_chinese_lunar_date_top
// gregorian to chinese lunar date converter, controller and datapath
// ----------------------------------------------------------------------------
module gregorian_to_chinese_lunar_date_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_greg_year,
  input  logic [3:0]  in_greg_month,
  input  logic [4:0]  in_greg_day,
  output logic        out_strobe,
  output logic        out_valid_res,
  output logic [11:0] out_lunar_year,
  output logic [3:0]  out_lunar_month,
  output logic [4:0]  out_lunar_day,
  output logic        out_leap_flag,
  output logic [3:0]  out_stem_index,
  output logic [3:0]  out_branch_index
);
  import g2l_pkg::*;

  g2l_cmd_t cmd;
  g2l_sts_t sts;

  g2l_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd),
    .busy(busy), .done(out_strobe)
  );

  g2l_dp u_dp (
    .clk(clk), .cmd(cmd), .in_year(in_greg_year), .in_month(in_greg_month),
    .in_day(in_greg_day), .sts(sts), .res_valid(out_valid_res),
    .res_year(out_lunar_year), .res_month(out_lunar_month),
    .res_day(out_lunar_day), .res_leap(out_leap_flag),
    .res_stem(out_stem_index), .res_branch(out_branch_index)
  );

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy) else $error("load while busy");
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> busy) else $error("not busy after load");
  a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy) else $error("busy after result beat");
`endif

endmodule

### rtl/core/g2l_ctrl.sv
// ----------------------------------------------------------------------------
// g2l_ctrl
// sequencer for the month walk: load, prep, step one month a cycle, report
// ----------------------------------------------------------------------------
module g2l_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  g2l_pkg::g2l_sts_t sts,
  output g2l_pkg::g2l_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import g2l_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_WALK, S_DONE} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_PREP;
      S_PREP: state_nxt = S_WALK;
      S_WALK: if (sts.hit || sts.last) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign cmd.load = (state_r == S_IDLE) && start;
  assign cmd.prep = (state_r == S_PREP);
  assign cmd.step = (state_r == S_WALK);
  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

### rtl/core/g2l_dp.sv
// ----------------------------------------------------------------------------
// g2l_dp
// datapath: input check, rom lookup, day offset and the month walk
// ----------------------------------------------------------------------------
module g2l_dp (
  input  logic              clk,
  input  g2l_pkg::g2l_cmd_t cmd,
  input  logic [11:0]       in_year,
  input  logic [3:0]        in_month,
  input  logic [4:0]        in_day,
  output g2l_pkg::g2l_sts_t sts,
  output logic              res_valid,
  output logic [11:0]       res_year,
  output logic [3:0]        res_month,
  output logic [4:0]        res_day,
  output logic              res_leap,
  output logic [3:0]        res_stem,
  output logic [3:0]        res_branch
);
  import g2l_pkg::*;

  logic        ok_r;
  logic [11:0] y_r, ly_r;
  logic [3:0]  m_r;
  logic [4:0]  d_r;
  logic [27:0] w_r;
  logic [9:0]  off_r;
  logic [3:0]  i_r, cnt_r, leap_r;
  logic [11:0] sz_r;
  logic        ls_r, lsdone_r;
  logic        hitv_r;
  logic [3:0]  lm_r, st_r, br_r;
  logic [4:0]  ld_r;
  logic        il_r;

  // first stage: check and rom
  logic        ok_c, pre_c;
  logic [IdxW-1:0] idx_c;
  logic [27:0] wc, wp;
  logic [10:0] m100;
  always_comb begin
    ok_c = (in_year > BaseYear) && (in_year <= LastYear) &&
           (in_month >= 4'd1) && (in_month <= 4'd12) && (in_day != 5'd0);
    idx_c = IdxW'(in_year - BaseYear);
    wc = rom_word(idx_c);
    wp = rom_word(idx_c - 1'b1);
    m100 = {7'd0, in_month} * 11'd100 + {6'd0, in_day};
    pre_c = m100 < {3'd0, wc[7:0]};
  end

  // ny month/day from word, new year always in jan or feb
  logic [3:0]  nym;
  logic [6:0]  nyd;
  logic [8:0]  doy_in, doy_ny, ylen;
  logic        lp_in, lp_ly;
  always_comb begin
    nym = (w_r[7:0] >= 8'd200) ? 4'd2 : 4'd1;
    nyd = (w_r[7:0] >= 8'd200) ? 7'(w_r[7:0] - 8'd200) : 7'(w_r[7:0] - 8'd100);
    lp_in = is_leap(y_r);
    lp_ly = is_leap(ly_r);
    doy_in = days_before(m_r) + {4'd0, d_r} + ((m_r > 4'd2 && lp_in) ? 9'd1 : 9'd0);
    doy_ny = days_before(nym) + {2'd0, nyd};
    ylen = lp_ly ? 9'd366 : 9'd365;
  end

  // stem and branch by reciprocal multiply, exact for years below 4096
  logic [11:0] yb;
  logic [23:0] p10, p12;
  logic [11:0] q10, q12;
  logic [3:0]  r10, r12;
  always_comb begin
    yb = ly_r - 12'd4;
    p10 = {12'd0, yb} * 24'd3277;
    p12 = {12'd0, yb} * 24'd2731;
    q10 = {3'd0, p10[23:15]};
    q12 = {3'd0, p12[23:15]};
    r10 = 4'(yb - ((q10 << 3) + (q10 << 1)));
    r12 = 4'(yb - ((q12 << 3) + (q12 << 2)));
  end

  logic [4:0] days_c;
  logic       cur_sz, is_lp_slot;
  always_comb begin
    is_lp_slot = (leap_r != 4'd0) && lsdone_r == 1'b0 && (i_r == leap_r);
    cur_sz = is_lp_slot ? ls_r : sz_r[11];
    days_c = cur_sz ? 5'd30 : 5'd29;
  end

  logic [3:0] slot_c;
  assign slot_c = cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok_r <= ok_c;
      y_r <= in_year;
      m_r <= in_month;
      d_r <= in_day;
      w_r <= pre_c ? wp : wc;
      ly_r <= pre_c ? in_year - 12'd1 : in_year;
      hitv_r <= 1'b0;
      lm_r <= '0; ld_r <= '0; il_r <= 1'b0;
      off_r <= {1'b0, pre_c, 8'd0};
      i_r <= '0;
      cnt_r <= '0;
      lsdone_r <= 1'b0;
    end else if (cmd.prep) begin
      // prep cycle
      off_r <= (off_r[8] ? (10'(ylen) - 10'(doy_ny) + 10'(doy_in))
                         : (10'(doy_in) - 10'(doy_ny))) + 10'd1;
      sz_r <= w_r[27:16];
      ls_r <= w_r[15:12] != 4'd0;
      leap_r <= (w_r[11:8] > 4'd12) ? 4'd0 : w_r[11:8];
      st_r <= r10;
      br_r <= r12;
    end else if (cmd.step && !hitv_r) begin
      if (off_r > 10'(days_c)) begin
        off_r <= off_r - 10'(days_c);
      end else begin
        hitv_r <= 1'b1;
        ld_r <= off_r[4:0];
        if (leap_r != 4'd0 && (slot_c + 4'd1) > leap_r) begin
          lm_r <= slot_c;
          il_r <= slot_c == leap_r;
        end else begin
          lm_r <= slot_c + 4'd1;
        end
      end
      cnt_r <= cnt_r + 4'd1;
      if (is_lp_slot) lsdone_r <= 1'b1;
      else begin
        sz_r <= {sz_r[10:0], 1'b0};
        i_r <= i_r + 4'd1;
      end
    end
  end

  logic hit_now;
  assign hit_now = !(off_r > 10'(days_c));
  assign sts.hit = cmd.step && (hit_now || !ok_r);
  assign sts.last = cmd.step && (cnt_r == ((leap_r != 4'd0) ? 4'd12 : 4'd11));

  always_comb begin
    res_valid = ok_r;
    res_year = ok_r ? ly_r : '0;
    res_month = ok_r ? lm_r : '0;
    res_day = ok_r ? ld_r : '0;
    res_leap = ok_r ? il_r : 1'b0;
    res_stem = ok_r ? st_r : '0;
    res_branch = ok_r ? br_r : '0;
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the gregorian to lunar date converter against a local predictor: a
// directed set of edge dates and rejected inputs, then random beats with
// random gaps; every result beat is compared field by field in order
// ----------------------------------------------------------------------------
typedef struct packed {
  bit        valid_res;
  bit [11:0] year_num;
  bit [3:0]  lunar_month;
  bit [4:0]  lunar_day;
  bit        leap_flag;
  bit [3:0]  stem_index;
  bit [3:0]  branch_index;
} lunar_date_t;

class lunar_scoreboard;
  lunar_date_t pending_dates[$];
  int mismatches;
  int checked;
  int rejected;
  int leap_hits;
  int past_year;

  bit [27:0] year_words[202] = '{
    28'hAB500D2, 28'h4BD0883, 28'h4AE00DB, 28'hA5700D0, 28'h54D0581,
    28'hD2600D8, 28'hD9500CC, 28'h655147D, 28'h56A00D5, 28'h9AD00CA,
    28'h55D027A, 28'h4AE00D2, 28'hA5B0682, 28'hA4D00DA, 28'hD2500CE,
    28'hD25157E, 28'hB5500D6, 28'h56A00CC, 28'hADA027B, 28'h95B00D3,
    28'h49717C9, 28'h49B00DC, 28'hA4B00D0, 28'hB4B0580, 28'h6A500D8,
    28'h6D400CD, 28'hAB5147C, 28'h2B600D5, 28'h95700CA, 28'h52F027B,
    28'h49700D2, 28'h6560682, 28'hD4A00D9, 28'hEA500CE, 28'h6A9157E,
    28'h5AD00D6, 28'h2B600CC, 28'h86E137C, 28'h92E00D3, 28'hC8D1783,
    28'hC9500DB, 28'hD4A00D0, 28'hD8A167F, 28'hB5500D7, 28'h56A00CD,
    28'hA5B147D, 28'h25D00D5, 28'h92D00CA, 28'hD2B027A, 28'hA9500D2,
    28'hB550781, 28'h6CA00D9, 28'hB5500CE, 28'h535157F, 28'h4DA00D6,
    28'hA5B00CB, 28'h457037C, 28'h52B00D4, 28'hA9A0883, 28'hE9500DA,
    28'h6AA00D0, 28'hAEA0680, 28'hAB500D7, 28'h4B600CD, 28'hAAE047D,
    28'hA5700D5, 28'h52600CA, 28'hF260379, 28'hD9500D1, 28'h5B50782,
    28'h56A00D9, 28'h96D00CE, 28'h4DD057F, 28'h4AD00D7, 28'hA4D00CB,
    28'hD4D047B, 28'hD2500D3, 28'hD550883, 28'hB5400DA, 28'hB6A00CF,
    28'h95A1680, 28'h95B00D8, 28'h49B00CD, 28'hA97047D, 28'hA4B00D5,
    28'hB270ACA, 28'h6A500DC, 28'h6D400D1, 28'hAF40681, 28'hAB600D9,
    28'h93700CE, 28'h4AF057F, 28'h49700D7, 28'h64B00CC, 28'h74A037B,
    28'hEA500D2, 28'h6B50883, 28'h5AC00DB, 28'hAB600CF, 28'h96D0580,
    28'h92E00D8, 28'hC9600CD, 28'hD95047C, 28'hD4A00D4, 28'hDA500C9,
    28'h755027A, 28'h56A00D1, 28'hABB0781, 28'h25D00DA, 28'h92D00CF,
    28'hCAB057E, 28'hA9500D6, 28'hB4A00CB, 28'hBAA047B, 28'hAD500D2,
    28'h55D0983, 28'h4BA00DB, 28'hA5B00D0, 28'h5171680, 28'h52B00D8,
    28'hA9300CD, 28'h795047D, 28'h6AA00D4, 28'hAD500C9, 28'h5B5027A,
    28'h4B600D2, 28'h96E0681, 28'hA4E00D9, 28'hD2600CE, 28'hEA6057E,
    28'hD5300D5, 28'h5AA00CB, 28'h76A037B, 28'h96D00D3, 28'h4AB0B83,
    28'h4AD00DB, 28'hA4D00D0, 28'hD0B1680, 28'hD2500D7, 28'hD5200CC,
    28'hDD4057C, 28'hB5A00D4, 28'h56D00C9, 28'h55B027A, 28'h49B00D2,
    28'hA570782, 28'hA4B00D9, 28'hAA500CE, 28'hB25157E, 28'h6D200D6,
    28'hADA00CA, 28'h4B6137B, 28'h93700D3, 28'h49F08C9, 28'h49700DB,
    28'h64B00D0, 28'h68A1680, 28'hEA500D7, 28'h6AA00CC, 28'hA6C147C,
    28'hAAE00D4, 28'h92E00CA, 28'hD2E0379, 28'hC9600D1, 28'hD550781,
    28'hD4A00D9, 28'hDA400CD, 28'h5D5057E, 28'h56A00D6, 28'hA6C00CB,
    28'h55D047B, 28'h52D00D3, 28'hA9B0883, 28'hA9500DB, 28'hB4A00CF,
    28'hB6A067F, 28'hAD500D7, 28'h55A00CD, 28'hABA047C, 28'hA5A00D4,
    28'h52B00CA, 28'hB27037A, 28'h69300D1, 28'h7330781, 28'h6AA00D9,
    28'hAD500CE, 28'h4B5157E, 28'h4B600D6, 28'hA5700CB, 28'h54E047C,
    28'hD1600D2, 28'hE960882, 28'hD5200DA, 28'hDAA00CF, 28'h6AA167F,
    28'h56D00D7, 28'h4AE00CD, 28'hA9D047D, 28'hA2D00D4, 28'hD1500C9,
    28'hF250279, 28'hD5200D1
  };

  int unsigned greg_month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  function int unsigned leap_greg(int unsigned yr);
    return ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0) ? 1 : 0;
  endfunction

  function int unsigned ordinal_day(int unsigned yr, int unsigned mon, int unsigned dy);
    int unsigned total;
    total = dy;
    for (int unsigned i = 1; i < mon && i <= 12; i++) begin
      total += greg_month_days[i-1];
      if (i == 2) total += leap_greg(yr);
    end
    return total;
  endfunction

  function lunar_date_t convert(bit [11:0] gy, bit [3:0] gm, bit [4:0] gd);
    lunar_date_t r;
    int unsigned yr, mon, dy, word, ny, ly, offset, leap_pos, leap_big, count, days;
    bit month_big[13];
    r = '0;
    yr = gy;
    mon = gm;
    dy = gd;
    if (yr < 1900 || yr > 2100 || mon < 1 || mon > 12 || dy < 1) return r;
    word = year_words[yr - 1899];
    ny = word & 8'hFF;
    ly = yr;
    if (mon * 100 + dy < ny) begin
      word = year_words[yr - 1900];
      ny = word & 8'hFF;
      ly = yr - 1;
      offset = (365 + leap_greg(ly)) - ordinal_day(ly, ny / 100, ny % 100)
               + ordinal_day(yr, mon, dy);
    end else begin
      offset = ordinal_day(yr, mon, dy) - ordinal_day(yr, ny / 100, ny % 100);
    end
    offset += 1;
    leap_pos = (word >> 8) & 4'hF;
    if (leap_pos > 12) leap_pos = 0;
    leap_big = (((word >> 12) & 4'hF) != 0) ? 1 : 0;
    count = 0;
    for (int unsigned i = 0; i < 12; i++) begin
      month_big[count] = 1'((word >> (27 - i)) & 1);
      count++;
      if (leap_pos != 0 && i + 1 == leap_pos) begin
        month_big[count] = 1'(leap_big);
        count++;
      end
    end
    for (int unsigned i = 0; i < count; i++) begin
      days = 29 + month_big[i];
      if (offset > days) begin
        offset -= days;
      end else begin
        if (leap_pos != 0 && i + 1 > leap_pos) begin
          r.lunar_month = 4'(i);
          r.leap_flag = (i == leap_pos);
        end else begin
          r.lunar_month = 4'(i + 1);
        end
        r.lunar_day = 5'(offset);
        break;
      end
    end
    r.valid_res = 1'b1;
    r.year_num = 12'(ly);
    r.stem_index = 4'((ly - 4) % 10);
    r.branch_index = 4'((ly - 4) % 12);
    return r;
  endfunction

  function void note_request(bit [11:0] gy, bit [3:0] gm, bit [4:0] gd);
    pending_dates.insert(pending_dates.size(), convert(gy, gm, gd));
  endfunction

  function void check_result(lunar_date_t got);
    lunar_date_t exp_date;
    checked++;
    if (pending_dates.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
      return;
    end
    exp_date = pending_dates.pop_front();
    if (!got.valid_res) rejected++;
    if (got.leap_flag) leap_hits++;
    if (got.valid_res && got.lunar_month == 0) past_year++;
    if (got != exp_date) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch at %0t: exp v%0d %0d/%0d/%0d leap%0d s%0d b%0d, ",
                  "got v%0d %0d/%0d/%0d leap%0d s%0d b%0d"},
                 $time, exp_date.valid_res, exp_date.year_num, exp_date.lunar_month,
                 exp_date.lunar_day, exp_date.leap_flag, exp_date.stem_index,
                 exp_date.branch_index, got.valid_res, got.year_num, got.lunar_month,
                 got.lunar_day, got.leap_flag, got.stem_index, got.branch_index);
    end
  endfunction
endclass

module testbench;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [11:0] in_greg_year = '0;
  logic [3:0]  in_greg_month = '0;
  logic [4:0]  in_greg_day = '0;
  logic        out_strobe;
  logic        out_valid_res;
  logic [11:0] out_lunar_year;
  logic [3:0]  out_lunar_month;
  logic [4:0]  out_lunar_day;
  logic        out_leap_flag;
  logic [3:0]  out_stem_index;
  logic [3:0]  out_branch_index;

  lunar_scoreboard dates = new();
  int sent;

  gregorian_to_chinese_lunar_date_top dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    lunar_date_t got;
    if (rst_n && out_strobe) begin
      got.valid_res = out_valid_res;
      got.year_num = out_lunar_year;
      got.lunar_month = out_lunar_month;
      got.lunar_day = out_lunar_day;
      got.leap_flag = out_leap_flag;
      got.stem_index = out_stem_index;
      got.branch_index = out_branch_index;
      dates.check_result(got);
    end
  end

  // one beat: optional gap with start low, then hold start until the block takes it
  task automatic convert_date(bit [11:0] gy, bit [3:0] gm, bit [4:0] gd, int gap);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    in_greg_year <= gy;
    in_greg_month <= gm;
    in_greg_day <= gd;
    start <= 1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    dates.note_request(gy, gm, gd);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int gap_max;
    int wait_cycles;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed edge dates
    convert_date(12'd1900, 4'd1, 5'd1, 0);
    convert_date(12'd1900, 4'd1, 5'd31, 0);
    convert_date(12'd1900, 4'd2, 5'd29, 0);
    convert_date(12'd2000, 4'd2, 5'd29, 1);
    convert_date(12'd2000, 4'd2, 5'd30, 0);
    convert_date(12'd2100, 4'd12, 5'd31, 0);
    convert_date(12'd2100, 4'd1, 5'd1, 3);
    convert_date(12'd2023, 4'd3, 5'd22, 0);
    convert_date(12'd2023, 4'd4, 5'd19, 0);
    convert_date(12'd2023, 4'd1, 5'd21, 0);
    convert_date(12'd2023, 4'd1, 5'd22, 0);
    convert_date(12'd2020, 4'd5, 5'd23, 2);
    convert_date(12'd1899, 4'd6, 5'd15, 0);
    convert_date(12'd2101, 4'd6, 5'd15, 0);
    convert_date(12'd4095, 4'd15, 5'd31, 0);
    convert_date(12'd0, 4'd0, 5'd0, 0);
    convert_date(12'd1999, 4'd0, 5'd10, 0);
    convert_date(12'd1999, 4'd13, 5'd10, 0);
    convert_date(12'd1999, 4'd15, 5'd10, 0);
    convert_date(12'd1999, 4'd7, 5'd0, 0);
    convert_date(12'd1987, 4'd12, 5'd31, 0);
    convert_date(12'd1984, 4'd2, 5'd2, 0);
    // random dates, mostly in range; bursts with no gaps now and then
    for (int blk = 0; blk < 38; blk++) begin
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 9) < 8)
          convert_date(12'($urandom_range(1900, 2100)), 4'($urandom_range(1, 12)),
                       5'($urandom_range(1, 31)), int'($urandom_range(0, gap_max)));
        else
          convert_date(12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)),
                       5'($urandom_range(0, 31)), int'($urandom_range(0, gap_max)));
      end
    end
    start <= 0;
    wait_cycles = 0;
    while (dates.pending_dates.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    $display("converted %0d dates: %0d rejected, %0d in leap months, %0d past year end",
             sent, dates.rejected, dates.leap_hits, dates.past_year);
    $display("%0d result beats checked, %0d mismatches, %0d left waiting",
             dates.checked, dates.mismatches, dates.pending_dates.size());
    if (dates.mismatches == 0 && dates.pending_dates.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
